>>> hw/rtl/imucal_pkg.sv
// Shared types, constants and helper functions for the IMU offset calibrator.
`timescale 1ns / 1ps

package imucal_pkg;

	localparam int AXIS_COUNT  = 6;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 32;
	localparam int COUNT_W     = 16;
	localparam int DISCARD_W   = 8;
	localparam int TARGET_W    = COUNT_W + 1;
	localparam int AXIS_W      = $clog2(AXIS_COUNT);
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [COUNT_W-1:0]   SAMPLE_COUNT_RESET = 16'd10000;
	localparam logic [DISCARD_W-1:0] DISCARD_COUNT_RESET = 8'd100;
	localparam logic signed [16:0]   ONE_G = 17'sd16384;
	localparam logic [SAMPLE_W-1:0]  KEEP_MASK = 16'h0001;

	// Axis order inside the accumulator array and the quotient array.
	localparam int AXIS_ACCEL_X = 0;
	localparam int AXIS_ACCEL_Y = 1;
	localparam int AXIS_ACCEL_Z = 2;
	localparam int AXIS_GYRO_X  = 3;
	localparam int AXIS_GYRO_Y  = 4;
	localparam int AXIS_GYRO_Z  = 5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_COUNT   = 3'd0,
		REG_DISCARD_COUNT  = 3'd1,
		REG_PRIOR_ACCEL_X  = 3'd2,
		REG_PRIOR_ACCEL_Y  = 3'd3,
		REG_PRIOR_ACCEL_Z  = 3'd4,
		REG_PRIOR_GYRO_X   = 3'd5,
		REG_PRIOR_GYRO_Y   = 3'd6,
		REG_PRIOR_GYRO_Z   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
		logic signed [SAMPLE_W-1:0] gyro_x;
		logic signed [SAMPLE_W-1:0] gyro_y;
		logic signed [SAMPLE_W-1:0] gyro_z;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean_accel_x;
		logic signed [SAMPLE_W-1:0] mean_accel_y;
		logic signed [SAMPLE_W-1:0] mean_accel_z;
		logic signed [SAMPLE_W-1:0] mean_gyro_x;
		logic signed [SAMPLE_W-1:0] mean_gyro_y;
		logic signed [SAMPLE_W-1:0] mean_gyro_z;
		logic signed [SAMPLE_W-1:0] new_accel_offset_x;
		logic signed [SAMPLE_W-1:0] new_accel_offset_y;
		logic signed [SAMPLE_W-1:0] new_accel_offset_z;
		logic signed [SAMPLE_W-1:0] new_gyro_offset_x;
		logic signed [SAMPLE_W-1:0] new_gyro_offset_y;
		logic signed [SAMPLE_W-1:0] new_gyro_offset_z;
	} out_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0]         sample_count;
		logic [DISCARD_W-1:0]       discard_count;
		logic signed [SAMPLE_W-1:0] prior_accel_x;
		logic signed [SAMPLE_W-1:0] prior_accel_y;
		logic signed [SAMPLE_W-1:0] prior_accel_z;
		logic signed [SAMPLE_W-1:0] prior_gyro_x;
		logic signed [SAMPLE_W-1:0] prior_gyro_y;
		logic signed [SAMPLE_W-1:0] prior_gyro_z;
	} cfg_t;

	// One finished run: the six sums and the divisor that goes with them.
	typedef struct packed {
		logic [AXIS_COUNT-1:0][SUM_W-1:0] sums;
		logic [TARGET_W-1:0]              target;
	} run_t;

	// Signed division by 8, truncating toward zero.
	function automatic logic signed [16:0] sdiv8(input logic signed [16:0] v);
		logic signed [16:0] b;
		b = v + (v[16] ? 17'sd7 : 17'sd0);
		return b >>> 3;
	endfunction

	// Signed division by 4, truncating toward zero.
	function automatic logic signed [16:0] sdiv4(input logic signed [16:0] v);
		logic signed [16:0] b;
		b = v + (v[16] ? 17'sd3 : 17'sd0);
		return b >>> 2;
	endfunction

endpackage

>>> hw/rtl/imucal_front.sv
// Front end: discard counting, per-axis accumulation and hand-off of finished runs.
`timescale 1ns / 1ps

module imucal_front
	import imucal_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     push_valid,
	input  logic     push_ready,
	output run_t     push_data
);

	logic [AXIS_COUNT-1:0][SUM_W-1:0] sums_q;
	logic [COUNT_W-1:0]               taken_q;
	logic [DISCARD_W-1:0]             discarded_q;

	logic [AXIS_COUNT-1:0][SAMPLE_W-1:0] sample;
	logic [AXIS_COUNT-1:0][SUM_W-1:0]    sums_next;
	logic [TARGET_W-1:0] target;
	logic [TARGET_W-1:0] taken_next;
	logic discarding;
	logic completing;
	logic accept;

	always_comb begin
		sample[AXIS_ACCEL_X] = in_data.accel_x;
		sample[AXIS_ACCEL_Y] = in_data.accel_y;
		sample[AXIS_ACCEL_Z] = in_data.accel_z;
		sample[AXIS_GYRO_X]  = in_data.gyro_x;
		sample[AXIS_GYRO_Y]  = in_data.gyro_y;
		sample[AXIS_GYRO_Z]  = in_data.gyro_z;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			sums_next[i] = sums_q[i]
				+ {{(SUM_W-SAMPLE_W){sample[i][SAMPLE_W-1]}}, sample[i]};
		end
	end

	// A sample count of zero stands for a full 65536-sample run.
	assign target     = (cfg.sample_count == '0) ? {1'b1, {COUNT_W{1'b0}}}
	                                             : {1'b0, cfg.sample_count};
	assign taken_next = {1'b0, taken_q} + TARGET_W'(1);
	assign discarding = discarded_q < cfg.discard_count;
	assign completing = !discarding && (taken_next >= target);

	// Only the word that closes a run needs room in the queue.
	assign in_ready   = !completing || push_ready;
	assign accept     = in_valid && in_ready;

	assign push_valid       = accept && completing;
	assign push_data.sums   = sums_next;
	assign push_data.target = target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q      <= '0;
			taken_q     <= '0;
			discarded_q <= '0;
		end else if (accept) begin
			if (discarding) begin
				discarded_q <= discarded_q + DISCARD_W'(1);
			end else if (completing) begin
				sums_q      <= '0;
				taken_q     <= '0;
				discarded_q <= '0;
			end else begin
				sums_q  <= sums_next;
				taken_q <= taken_next[COUNT_W-1:0];
			end
		end
	end

endmodule

>>> hw/rtl/imucal_queue.sv
// Small queue of finished runs between the front end and the back end.
`timescale 1ns / 1ps

module imucal_queue
	import imucal_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_data,
	output logic full,
	input  logic pop,
	output run_t head,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	run_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/imucal_div.sv
// Bit-serial signed divider: one quotient bit per cycle, result wrapped to 16 bits.
`timescale 1ns / 1ps

module imucal_div
	import imucal_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_W-1:0]    dividend,
	input  logic [TARGET_W-1:0]        divisor,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]    dq_q;
	logic [TARGET_W-1:0] rem_q;
	logic [TARGET_W-1:0] div_q;
	logic                neg_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;

	logic [TARGET_W:0]   rem_shift;
	logic [TARGET_W:0]   rem_diff;
	logic                fits;

	// The dividend register shifts out its top bit while quotient bits shift in below.
	assign rem_shift = {rem_q, dq_q[SUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign fits      = rem_shift >= {1'b0, div_q};

	assign done     = done_q;
	assign quotient = neg_q ? -dq_q[SAMPLE_W-1:0] : dq_q[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			dq_q  <= dividend[SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[SUM_W-2:0], fits};
			rem_q <= fits ? rem_diff[TARGET_W-1:0] : rem_shift[TARGET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/imucal_back.sv
// Back end: divides each queued run axis by axis, forms the offsets and holds the result.
`timescale 1ns / 1ps

module imucal_back
	import imucal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  run_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_START,
		B_WAIT,
		B_EMIT
	} back_state_t;

	back_state_t                         state_q;
	logic [AXIS_W-1:0]                   axis_q;
	logic [AXIS_COUNT-1:0][SAMPLE_W-1:0] mean_q;
	logic                                out_valid_q;
	out_word_t                           out_data_q;

	logic                       div_start;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] div_quot;
	logic                       out_free;
	out_word_t                  result;

	logic signed [16:0] corr_ax;
	logic signed [16:0] corr_ay;
	logic signed [16:0] corr_az;
	logic signed [16:0] corr_gx;
	logic signed [16:0] corr_gy;
	logic signed [16:0] corr_gz;

	assign div_start = state_q == B_START;
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == B_EMIT) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	imucal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head.sums[axis_q]),
		.divisor  (head.target),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		corr_ax = sdiv8({mean_q[AXIS_ACCEL_X][SAMPLE_W-1], mean_q[AXIS_ACCEL_X]});
		corr_ay = sdiv8({mean_q[AXIS_ACCEL_Y][SAMPLE_W-1], mean_q[AXIS_ACCEL_Y]});
		// Z is measured against one g, so its correction starts from 1 g minus the mean.
		corr_az = sdiv8(ONE_G
			- {mean_q[AXIS_ACCEL_Z][SAMPLE_W-1], mean_q[AXIS_ACCEL_Z]});
		corr_gx = sdiv4({mean_q[AXIS_GYRO_X][SAMPLE_W-1], mean_q[AXIS_GYRO_X]});
		corr_gy = sdiv4({mean_q[AXIS_GYRO_Y][SAMPLE_W-1], mean_q[AXIS_GYRO_Y]});
		corr_gz = sdiv4({mean_q[AXIS_GYRO_Z][SAMPLE_W-1], mean_q[AXIS_GYRO_Z]});

		result.mean_accel_x = mean_q[AXIS_ACCEL_X];
		result.mean_accel_y = mean_q[AXIS_ACCEL_Y];
		result.mean_accel_z = mean_q[AXIS_ACCEL_Z];
		result.mean_gyro_x  = mean_q[AXIS_GYRO_X];
		result.mean_gyro_y  = mean_q[AXIS_GYRO_Y];
		result.mean_gyro_z  = mean_q[AXIS_GYRO_Z];

		result.new_accel_offset_x = (cfg.prior_accel_x - corr_ax[SAMPLE_W-1:0])
			| (cfg.prior_accel_x & KEEP_MASK);
		result.new_accel_offset_y = (cfg.prior_accel_y - corr_ay[SAMPLE_W-1:0])
			| (cfg.prior_accel_y & KEEP_MASK);
		result.new_accel_offset_z = (cfg.prior_accel_z - corr_az[SAMPLE_W-1:0])
			| (cfg.prior_accel_z & KEEP_MASK);
		result.new_gyro_offset_x  = cfg.prior_gyro_x - corr_gx[SAMPLE_W-1:0];
		result.new_gyro_offset_y  = cfg.prior_gyro_y - corr_gy[SAMPLE_W-1:0];
		result.new_gyro_offset_z  = cfg.prior_gyro_z - corr_gz[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			axis_q      <= '0;
			mean_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && !pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						axis_q  <= '0;
						state_q <= B_START;
					end
				end
				B_START: begin
					state_q <= B_WAIT;
				end
				B_WAIT: begin
					if (div_done) begin
						mean_q[axis_q] <= div_quot;
						if (axis_q == AXIS_W'(AXIS_COUNT - 1)) begin
							state_q <= B_EMIT;
						end else begin
							axis_q  <= axis_q + AXIS_W'(1);
							state_q <= B_START;
						end
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_data_q  <= result;
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/imu_offset_calibrator_top.sv
// Top level of the IMU offset calibrator: configuration registers and the three stages.
//
// Usage:
// - in channel (in_valid/in_ready/in_data): one six-axis sample per word. The first
//   discard_count words of a run are dropped, the next sample_count words are summed.
//   Words are taken one per cycle; in_ready drops only while the next word would close
//   a run and the run queue (QUEUE_DEPTH entries) is full.
// - out channel (out_valid/out_ready/out_data): one word per run with the six means
//   and the six new offsets. out_data is registered and holds while out_ready is low.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes register cfg_index;
//   cfg_ready is always high. Write only while no run is pending.
// Divider: a closed run waits in the queue, then the back end divides its six sums one
//   after another in a bit-serial divider. It takes the next run only after it has
//   registered the result, while the front end goes on summing the following run.
// Reset: counters and sums clear, sample_count returns to 10000, discard_count to 100,
//   the prior offsets to zero, and the queue and output empty.
// A stalled receiver first holds the back end, then fills the queue, and only then
//   pushes back on the input at the closing word of the next run.
`timescale 1ns / 1ps

module imu_offset_calibrator_top
	import imucal_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	logic push_valid;
	logic q_full;
	logic q_empty;
	logic q_pop;
	run_t push_data;
	run_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count  <= SAMPLE_COUNT_RESET;
			cfg_q.discard_count <= DISCARD_COUNT_RESET;
			cfg_q.prior_accel_x <= '0;
			cfg_q.prior_accel_y <= '0;
			cfg_q.prior_accel_z <= '0;
			cfg_q.prior_gyro_x  <= '0;
			cfg_q.prior_gyro_y  <= '0;
			cfg_q.prior_gyro_z  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_COUNT:  cfg_q.sample_count  <= cfg_data;
				REG_DISCARD_COUNT: cfg_q.discard_count <= cfg_data[DISCARD_W-1:0];
				REG_PRIOR_ACCEL_X: cfg_q.prior_accel_x <= cfg_data;
				REG_PRIOR_ACCEL_Y: cfg_q.prior_accel_y <= cfg_data;
				REG_PRIOR_ACCEL_Z: cfg_q.prior_accel_z <= cfg_data;
				REG_PRIOR_GYRO_X:  cfg_q.prior_gyro_x  <= cfg_data;
				REG_PRIOR_GYRO_Y:  cfg_q.prior_gyro_y  <= cfg_data;
				REG_PRIOR_GYRO_Z:  cfg_q.prior_gyro_z  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	imucal_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (!q_full),
		.push_data  (push_data)
	);

	imucal_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	imucal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> hw/rtl/imucal_checker.sv
// Port-level checker for the IMU offset calibrator, bound to the top level.
`timescale 1ns / 1ps

module imucal_checker
	import imucal_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input in_word_t               in_data,
	input logic                   out_valid,
	input logic                   out_ready,
	input out_word_t              out_data,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data
);

	logic                       keep_ax_q;
	logic signed [SAMPLE_W-1:0] prior_gx_q;
	logic signed [16:0]         gx_corr;

	// Shadow copies of the registers that the checks below depend on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_ax_q  <= 1'b0;
			prior_gx_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_PRIOR_ACCEL_X) begin
				keep_ax_q <= cfg_data[0];
			end
			if (cfg_index == REG_PRIOR_GYRO_X) begin
				prior_gx_q <= cfg_data;
			end
		end
	end

	assign gx_corr = sdiv4({out_data.mean_gyro_x[SAMPLE_W-1], out_data.mean_gyro_x});

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed or dropped while stalled");

	a_keep_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keep_ax_q |-> out_data.new_accel_offset_x[0])
		else $error("kept bit of the accel X offset was lost");

	a_gyro_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.new_gyro_offset_x == prior_gx_q - gx_corr[SAMPLE_W-1:0])
		else $error("gyro X offset does not follow from its mean");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was refused");

endmodule

bind imu_offset_calibrator_top imucal_checker u_imucal_checker (.*);

>>> dv/tb_imu_offset_calibrator_top.sv
// Self-checking testbench for the IMU offset calibrator: predicted means and offsets per run.
`timescale 1ns / 1ps

module tb_imu_offset_calibrator_top;
	import imucal_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int SETTLE_WAIT  = 250;
	localparam int ACCEL_SCALE  = 8;
	localparam int GYRO_SCALE   = 4;
	localparam int FIELD_COUNT  = 12;
	localparam int OUT_W        = $bits(out_word_t);
	localparam int IN_W         = $bits(in_word_t);

	// Tracks the calibrator's run state and holds the results it should produce, oldest first.
	class offset_tracker;
		logic [COUNT_W-1:0]   count_reg;
		logic [DISCARD_W-1:0] drop_reg;
		logic [SAMPLE_W-1:0]  accel_prior [3];
		logic [SAMPLE_W-1:0]  gyro_prior [3];
		logic [SUM_W-1:0]     sums [AXIS_COUNT];
		logic [COUNT_W-1:0]   taken;
		logic [DISCARD_W-1:0] dropped;
		out_word_t            pending_results [$];
		int                   errors;
		int                   reported;
		int                   results_seen;
		string field_names [FIELD_COUNT] = '{"mean_accel_x", "mean_accel_y", "mean_accel_z",
			"mean_gyro_x", "mean_gyro_y", "mean_gyro_z", "new_accel_offset_x",
			"new_accel_offset_y", "new_accel_offset_z", "new_gyro_offset_x",
			"new_gyro_offset_y", "new_gyro_offset_z"};

		function new();
			count_reg = SAMPLE_COUNT_RESET;
			drop_reg = DISCARD_COUNT_RESET;
			for (int i = 0; i < 3; i++) begin
				accel_prior[i] = '0;
				gyro_prior[i] = '0;
			end
			for (int i = 0; i < AXIS_COUNT; i++)
				sums[i] = '0;
			taken = '0;
			dropped = '0;
			errors = 0;
			reported = 0;
			results_seen = 0;
		endfunction

		function void note_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SAMPLE_COUNT: count_reg = data;
				REG_DISCARD_COUNT: drop_reg = data[DISCARD_W-1:0];
				REG_PRIOR_ACCEL_X, REG_PRIOR_ACCEL_Y, REG_PRIOR_ACCEL_Z: begin
					accel_prior[int'(idx) - int'(REG_PRIOR_ACCEL_X)] = data;
				end
				default: begin
					gyro_prior[int'(idx) - int'(REG_PRIOR_GYRO_X)] = data;
				end
			endcase
		endfunction

		function void take_sample(in_word_t w);
			logic [SAMPLE_W-1:0] axis [AXIS_COUNT];
			logic [SAMPLE_W-1:0] mean [AXIS_COUNT];
			logic [SAMPLE_W-1:0] accel_new [3];
			logic [SAMPLE_W-1:0] gyro_new [3];
			longint target;
			int m;
			int corr;
			if (dropped < drop_reg) begin
				dropped++;
				return;
			end
			axis = '{w.accel_x, w.accel_y, w.accel_z, w.gyro_x, w.gyro_y, w.gyro_z};
			for (int i = 0; i < AXIS_COUNT; i++)
				sums[i] += {{(SUM_W - SAMPLE_W){axis[i][SAMPLE_W-1]}}, axis[i]};
			// A count of zero stands for a full 65536-sample run.
			target = (count_reg == 0) ? 65536 : longint'(count_reg);
			if (longint'(taken) + 1 < target) begin
				taken++;
				return;
			end
			for (int i = 0; i < AXIS_COUNT; i++)
				mean[i] = 16'(longint'($signed(sums[i])) / target);
			for (int i = 0; i < 3; i++) begin
				m = int'($signed(mean[i]));
				corr = (i == AXIS_ACCEL_Z) ? (int'(ONE_G) - m) / ACCEL_SCALE : m / ACCEL_SCALE;
				accel_new[i] = 16'(int'($signed(accel_prior[i])) - corr)
					| (accel_prior[i] & KEEP_MASK);
				m = int'($signed(mean[AXIS_GYRO_X + i]));
				gyro_new[i] = 16'(int'($signed(gyro_prior[i])) - m / GYRO_SCALE);
			end
			pending_results.push_back({mean[0], mean[1], mean[2], mean[3], mean[4], mean[5],
				accel_new[0], accel_new[1], accel_new[2], gyro_new[0], gyro_new[1], gyro_new[2]});
			for (int i = 0; i < AXIS_COUNT; i++)
				sums[i] = '0;
			taken = '0;
			dropped = '0;
		endfunction

		function void check_result(out_word_t got);
			logic [OUT_W-1:0] want_bits;
			logic [OUT_W-1:0] got_bits;
			if (pending_results.size() == 0) begin
				errors++;
				if (reported < 10)
					$display("result word arrived with none expected: %h", got);
				reported++;
				return;
			end
			want_bits = pending_results.pop_front();
			got_bits = got;
			results_seen++;
			for (int k = 0; k < FIELD_COUNT; k++) begin
				if (got_bits[OUT_W - 1 - 16 * k -: 16] !== want_bits[OUT_W - 1 - 16 * k -: 16]) begin
					errors++;
					if (reported < 10)
						$display("run %0d %s: expected %0d, got %0d", results_seen,
							field_names[k], $signed(want_bits[OUT_W - 1 - 16 * k -: 16]),
							$signed(got_bits[OUT_W - 1 - 16 * k -: 16]));
					reported++;
				end
			end
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_word_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_word_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	offset_tracker tracker;
	bit            steady_in;
	bit            steady_out;
	int            hold_request;
	int            cycle_count;

	imu_offset_calibrator_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_axis();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t rand_sample();
		logic [IN_W-1:0] v;
		for (int k = 0; k < AXIS_COUNT; k++)
			v[16 * k +: 16] = rand_axis();
		return v;
	endfunction

	task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		tracker.note_write(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_sample(input in_word_t w);
		int gap;
		gap = steady_in ? 0 : idle_gap();
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (!in_ready);
		tracker.take_sample(w);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Samples that close no run leave nothing to wait for, so allow the divider its time too.
	task automatic wait_idle();
		while (tracker.pending_count() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (steady_out) begin
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				stall_left = idle_gap();
			end else begin
				out_ready = 1'b1;
			end
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_result(out_data);
		end
	end

	initial begin
		in_word_t          w;
		in_word_t          base;
		logic [IN_W-1:0]   noisy;
		logic [COUNT_W-1:0] run_len;
		logic [DISCARD_W-1:0] drop_len;
		logic [CFG_DATA_W-1:0] value;
		int                n;
		int                style;
		int                random_items;
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady_in = 1'b1;
		steady_out = 1'b0;
		hold_request = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: the full discard, then a short run closed by a smaller sample count.
		repeat (int'(DISCARD_COUNT_RESET) + 10)
			send_sample(rand_sample());
		set_register(REG_SAMPLE_COUNT, 16'd12);
		repeat (2) send_sample(rand_sample());
		wait_idle();

		// Single-sample runs at the field extremes, odd and even priors.
		steady_in = 1'b0;
		set_register(REG_SAMPLE_COUNT, 16'd1);
		set_register(REG_DISCARD_COUNT, 16'd0);
		set_register(REG_PRIOR_ACCEL_X, 16'h0001);
		set_register(REG_PRIOR_ACCEL_Y, 16'h8000);
		set_register(REG_PRIOR_ACCEL_Z, 16'h7FFF);
		set_register(REG_PRIOR_GYRO_X, 16'h8000);
		set_register(REG_PRIOR_GYRO_Y, 16'h7FFF);
		set_register(REG_PRIOR_GYRO_Z, 16'hFFFF);
		send_sample({6{16'h0000}});
		send_sample({6{16'h7FFF}});
		send_sample({6{16'h8000}});
		send_sample({16'hFFF9, 16'hFFF7, 16'h4000, 16'hFFFD, 16'hFFFB, 16'h0003});
		send_sample({3{16'h5555, 16'hAAAA}});
		send_sample({3{16'hAAAA, 16'h5555}});
		send_sample({16'h0007, 16'h0008, 16'hC000, 16'h0004, 16'hFFFC, 16'h0001});
		wait_idle();

		// Two-sample runs: truncation of odd sums and new priors, some with a cleared low bit.
		set_register(REG_SAMPLE_COUNT, 16'd2);
		set_register(REG_PRIOR_ACCEL_X, 16'h7FFE);
		set_register(REG_PRIOR_ACCEL_Y, 16'h0003);
		set_register(REG_PRIOR_ACCEL_Z, 16'h8001);
		set_register(REG_PRIOR_GYRO_X, 16'h1234);
		set_register(REG_PRIOR_GYRO_Y, 16'hEDCB);
		set_register(REG_PRIOR_GYRO_Z, 16'h0000);
		send_sample({6{16'hFFFF}});
		send_sample({6{16'h0000}});
		send_sample({6{16'h8000}});
		send_sample({6{16'h8001}});
		send_sample({6{16'h7FFF}});
		send_sample({6{16'h7FFF}});
		send_sample({6{16'h0003}});
		send_sample({6{16'h0000}});
		wait_idle();

		// The receiver stalls long while every word closes a run, so the input backs up.
		set_register(REG_SAMPLE_COUNT, 16'd1);
		set_register(REG_DISCARD_COUNT, 16'd0);
		steady_in = 1'b1;
		hold_request = 2500;
		while (hold_request != 0)
			@(negedge clk);
		repeat (30) send_sample(rand_sample());
		wait_idle();

		// Longest discard.
		steady_in = 1'b0;
		set_register(REG_DISCARD_COUNT, 16'd255);
		repeat (256) send_sample(rand_sample());
		wait_idle();

		// A count of zero keeps the run open; then the count drops below the samples taken.
		set_register(REG_SAMPLE_COUNT, 16'd0);
		set_register(REG_DISCARD_COUNT, 16'd0);
		repeat (5) send_sample(rand_sample());
		wait_idle();
		set_register(REG_SAMPLE_COUNT, 16'd3);
		repeat (4) send_sample(rand_sample());
		wait_idle();

		// Discard count lowered while samples are still being dropped.
		set_register(REG_SAMPLE_COUNT, 16'd2);
		set_register(REG_DISCARD_COUNT, 16'd10);
		repeat (3) send_sample(rand_sample());
		wait_idle();
		set_register(REG_DISCARD_COUNT, 16'd2);
		repeat (2) send_sample(rand_sample());
		wait_idle();

		// Random phases of short runs with fresh settings between them.
		random_items = 0;
		while (random_items < 600 || tracker.results_seen < 60) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: run_len = 16'd1;
				1, 2: run_len = 16'($urandom_range(9, 40));
				default: run_len = 16'($urandom_range(2, 8));
			endcase
			drop_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 30))
				: 8'($urandom_range(0, 3));
			for (int r = 0; r < 8; r++) begin
				case (cfg_reg_t'(r))
					REG_SAMPLE_COUNT: value = run_len;
					REG_DISCARD_COUNT: value = {8'd0, drop_len};
					default: value = rand_axis();
				endcase
				set_register(cfg_reg_t'(r), value);
			end
			steady_in = ($urandom_range(0, 3) == 0);
			steady_out = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 2);
			base = rand_sample();
			n = $urandom_range(10, 60);
			repeat (n) begin
				// Most phases sit near one reading so the means land across the whole range.
				if (style == 0) begin
					w = rand_sample();
				end else begin
					noisy = base;
					for (int k = 0; k < AXIS_COUNT; k++)
						noisy[16 * k +: 16] += 16'($urandom_range(0, 8)) - 16'd4;
					w = noisy;
				end
				send_sample(w);
				random_items++;
			end
		end
		wait_idle();

		if (tracker.errors == 0 && tracker.pending_count() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
